>>> rtl/adcir_pkg.sv
package adcir_pkg;

    localparam int CODE_W            = 12;
    localparam int COUNT_W           = 13;
    localparam int CFG_INDEX_W       = 4;
    localparam int FRAME_MAX_DEFAULT = 4096;
    localparam int REPAIR_CAP_LIMIT  = 4096;
    localparam int QUEUE_DEPTH       = 4;

    localparam logic [CODE_W-1:0] CODE_MAX        = 12'hFFF;
    localparam logic [CODE_W-1:0] THRESHOLD_RESET = 12'd512;
    localparam logic [CODE_W-1:0] LIMIT_RESET     = 12'd512;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] REG_SPIKE_THRESHOLD = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_NEIGHBOR_LIMIT  = 4'd1;

    typedef struct packed {
        logic [CODE_W-1:0] sample_code;
        logic              frame_end;
    } sample_beat_t;

    typedef struct packed {
        logic [CODE_W-1:0]  repaired_code;
        logic               was_repaired;
        logic               frame_done;
        logic [CODE_W-1:0]  frame_minimum;
        logic [CODE_W-1:0]  frame_maximum;
        logic [COUNT_W-1:0] repair_total;
    } result_beat_t;

    typedef struct packed {
        logic [CFG_INDEX_W-1:0] index;
        logic [CODE_W-1:0]      value;
    } cfg_beat_t;

    typedef struct packed {
        logic [CODE_W-1:0] spike_threshold;
        logic [CODE_W-1:0] neighbor_limit;
    } cfg_regs_t;

    // One classified work item for the back end.
    typedef struct packed {
        logic [CODE_W-1:0] center_code;
        logic [CODE_W-1:0] right_code;
        logic              emit_held;
        logic              center_is_first;
        logic              last;
    } cmd_t;

endpackage

>>> rtl/adcir_stream_if.sv
interface adcir_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/adcir_front.sv
module adcir_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  adcir_pkg::sample_beat_t in_data,
    output logic                 push_valid,
    output adcir_pkg::cmd_t      push_cmd,
    input  logic                 push_ready
);
    import adcir_pkg::*;

    logic              held_valid_reg, held_valid_next;
    logic              held_is_first_reg, held_is_first_next;
    logic [CODE_W-1:0] held_code_reg, held_code_next;
    logic              accept;

    assign in_ready = push_ready;
    assign accept   = in_valid && push_ready;

    // Frame-opening samples get held unless they also end the frame; everything else becomes a command.
    assign push_valid = accept && (held_valid_reg || in_data.frame_end);

    always_comb
    begin
        push_cmd.center_code     = held_code_reg;
        push_cmd.right_code      = in_data.sample_code;
        push_cmd.emit_held       = held_valid_reg;
        push_cmd.center_is_first = held_is_first_reg;
        push_cmd.last            = in_data.frame_end;
    end

    always_comb
    begin
        held_valid_next    = held_valid_reg;
        held_is_first_next = held_is_first_reg;
        held_code_next     = held_code_reg;
        if (accept)
        begin
            if (in_data.frame_end)
            begin
                held_valid_next    = 1'b0;
                held_is_first_next = 1'b0;
            end
            else
            begin
                held_valid_next    = 1'b1;
                held_is_first_next = !held_valid_reg;
                held_code_next     = in_data.sample_code;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_valid_reg    <= 1'b0;
            held_is_first_reg <= 1'b0;
        end
        else
        begin
            held_valid_reg    <= held_valid_next;
            held_is_first_reg <= held_is_first_next;
        end
    end

    always_ff @(posedge clk)
    begin
        held_code_reg <= held_code_next;
    end

endmodule

>>> rtl/adcir_queue.sv
module adcir_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push_valid,
    output logic            push_ready,
    input  adcir_pkg::cmd_t push_cmd,
    output logic            pop_valid,
    input  logic            pop,
    output adcir_pkg::cmd_t head
);
    import adcir_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(QUEUE_DEPTH);

    cmd_t             slots_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign push_ready = (count_reg != FULL_COUNT);
    assign pop_valid  = (count_reg != '0);
    assign head       = slots_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slots_reg[wr_ptr_reg] <= push_cmd;
    end

endmodule

>>> rtl/adcir_back.sv
module adcir_back #(
    parameter int FRAME_MAX = adcir_pkg::FRAME_MAX_DEFAULT
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  adcir_pkg::cfg_regs_t    cfg_regs,
    input  logic                    q_valid,
    input  adcir_pkg::cmd_t         q_head,
    output logic                    q_pop,
    output logic                    out_valid,
    input  logic                    out_ready,
    output adcir_pkg::result_beat_t out_data
);
    import adcir_pkg::*;

    localparam logic [COUNT_W-1:0] REPAIR_CAP = (FRAME_MAX < REPAIR_CAP_LIMIT)
        ? COUNT_W'(FRAME_MAX) : COUNT_W'(REPAIR_CAP_LIMIT);

    logic [CODE_W-1:0]  left_reg, left_next;
    logic [CODE_W-1:0]  min_reg, min_next;
    logic [CODE_W-1:0]  max_reg, max_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic               phase_reg, phase_next;
    logic               out_valid_reg, out_valid_next;
    result_beat_t       out_data_reg, out_data_next;

    logic              out_free, step_held, step_final, repair;
    logic [CODE_W:0]   mid_sum;
    logic [CODE_W-1:0] mid, dev, gap, held_result, final_min, final_max;

    assign out_free = !out_valid_reg || out_ready;

    // Repair decision for the held sample, left neighbor already repaired.
    assign mid_sum = {1'b0, left_reg} + {1'b0, q_head.right_code} + 1'b1;
    assign mid     = mid_sum[CODE_W:1];
    assign dev     = (q_head.center_code > mid) ? q_head.center_code - mid
                                                : mid - q_head.center_code;
    assign gap     = (left_reg > q_head.right_code) ? left_reg - q_head.right_code
                                                    : q_head.right_code - left_reg;
    assign repair  = !q_head.center_is_first && (dev >= cfg_regs.spike_threshold)
                     && (gap <= cfg_regs.neighbor_limit);
    assign held_result = repair ? mid : q_head.center_code;

    assign step_held  = q_valid && out_free && q_head.emit_held && !phase_reg;
    assign step_final = q_valid && out_free && q_head.last
                        && (phase_reg || !q_head.emit_held);
    assign q_pop      = step_final || (step_held && !q_head.last);

    assign final_min = (q_head.right_code < min_reg) ? q_head.right_code : min_reg;
    assign final_max = (q_head.right_code > max_reg) ? q_head.right_code : max_reg;

    always_comb
    begin
        left_next      = left_reg;
        min_next       = min_reg;
        max_next       = max_reg;
        count_next     = count_reg;
        phase_next     = phase_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg && !out_ready;
        if (step_held)
        begin
            left_next = held_result;
            if (held_result < min_reg)
                min_next = held_result;
            if (held_result > max_reg)
                max_next = held_result;
            if (repair && (count_reg < REPAIR_CAP))
                count_next = count_reg + 1'b1;
            phase_next     = q_head.last;
            out_valid_next = 1'b1;
            out_data_next  = '{repaired_code: held_result, was_repaired: repair,
                               frame_done: 1'b0, frame_minimum: '0,
                               frame_maximum: '0, repair_total: '0};
        end
        else if (step_final)
        begin
            left_next      = '0;
            min_next       = CODE_MAX;
            max_next       = '0;
            count_next     = '0;
            phase_next     = 1'b0;
            out_valid_next = 1'b1;
            out_data_next  = '{repaired_code: q_head.right_code, was_repaired: 1'b0,
                               frame_done: 1'b1, frame_minimum: final_min,
                               frame_maximum: final_max, repair_total: count_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg      <= '0;
            min_reg       <= CODE_MAX;
            max_reg       <= '0;
            count_reg     <= '0;
            phase_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            left_reg      <= left_next;
            min_reg       <= min_next;
            max_reg       <= max_next;
            count_reg     <= count_next;
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    a_phase_has_head: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg |-> (q_valid && q_head.last && q_head.emit_held))
        else $error("second beat pending without a matching queue head");

    a_phase_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (step_held && q_head.last) |=> phase_reg)
        else $error("frame end beat not scheduled after held sample");

    a_final_unrepaired: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_data_reg.frame_done) |-> !out_data_reg.was_repaired)
        else $error("last sample of a frame marked as repaired");

    a_stats_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_data_reg.frame_done) |->
        (out_data_reg.frame_minimum == '0 && out_data_reg.frame_maximum == '0
         && out_data_reg.repair_total == '0))
        else $error("frame statistics leaked into an inner beat");

endmodule

>>> rtl/adc_impulse_repair_filter.sv
// Channel     Role    Payload                                    Accepted when
// sample_in   sink    sample_code, frame_end                     valid && ready
// result_out  source  repaired_code, was_repaired, frame_done,  valid && ready
//                     frame_minimum, frame_maximum, repair_total
// cfg         sink    index, value                               valid && ready
//
// One sample beat is taken per cycle while the four-entry command queue has room.
// A held sample's result beat is decided once the beat carrying its right neighbor
// is taken; the command waits in a queue slot, then the result goes through the
// output register before it can be accepted.
// A frame's last sample that follows a held sample yields two result beats, which
// the back end emits one after the other through its single output register.
// Reset clears the held sample, the frame statistics, the queue and the
// registers (both thresholds return to 512); no clearing pass is needed.
// A stalled result_out fills the queue and then drops sample_in.ready.
module adc_impulse_repair_filter #(
    parameter int FRAME_MAX = adcir_pkg::FRAME_MAX_DEFAULT
) (
    input  logic           clk,
    input  logic           rst_n,
    adcir_stream_if.sink   sample_in,
    adcir_stream_if.source result_out,
    adcir_stream_if.sink   cfg
);
    import adcir_pkg::*;

    cfg_regs_t cfg_regs_reg, cfg_regs_next;
    cfg_beat_t cfg_beat;

    logic push_valid, push_ready, q_valid, q_pop;
    cmd_t push_cmd, q_head;

    // Register writes must only be issued while the filter is idle; the block
    // itself does not enforce this. The port can always take them.
    assign cfg.ready = 1'b1;
    assign cfg_beat  = cfg.data;

    always_comb
    begin
        cfg_regs_next = cfg_regs_reg;
        if (cfg.valid)
        begin
            // Writes to indexes past the register list are dropped.
            if (cfg_beat.index == REG_SPIKE_THRESHOLD)
                cfg_regs_next.spike_threshold = cfg_beat.value;
            else if (cfg_beat.index == REG_NEIGHBOR_LIMIT)
                cfg_regs_next.neighbor_limit = cfg_beat.value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_regs_reg.spike_threshold <= THRESHOLD_RESET;
            cfg_regs_reg.neighbor_limit  <= LIMIT_RESET;
        end
        else
        begin
            cfg_regs_reg <= cfg_regs_next;
        end
    end

    // The front end holds one sample and turns each new beat, except a held frame
    // opening one, into a command describing what the back end must emit.
    adcir_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (sample_in.valid),
        .in_ready   (sample_in.ready),
        .in_data    (sample_in.data),
        .push_valid (push_valid),
        .push_cmd   (push_cmd),
        .push_ready (push_ready)
    );

    // The queue lets the front keep taking samples while the back end is
    // stalled by the output or busy with a two-beat frame end.
    adcir_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd),
        .pop_valid  (q_valid),
        .pop        (q_pop),
        .head       (q_head)
    );

    // The back end owns the repaired left neighbor and the frame statistics.
    adcir_back #(
        .FRAME_MAX (FRAME_MAX)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_regs  (cfg_regs_reg),
        .q_valid   (q_valid),
        .q_head    (q_head),
        .q_pop     (q_pop),
        .out_valid (result_out.valid),
        .out_ready (result_out.ready),
        .out_data  (result_out.data)
    );

endmodule

>>> tb/adc_impulse_repair_filter_tb.sv
`timescale 1ns / 1ps

// Self-checking bench for the three-point impulse spike filter.
//
// The sample driver and the result monitor are clocked always blocks. The
// stimulus process only fills the queue of sample beats that wait to be sent,
// shapes the traffic and writes the two thresholds while the filter is quiet.
// Each sample beat is run through the bench's own copy of the filter when it
// is accepted. The result beats that the sample should cause are appended to
// the queue of awaited repairs, and the monitor checks every result beat
// against the oldest of them.
module adc_impulse_repair_filter_tb;

    import adcir_pkg::*;

    localparam int CLK_HALF        = 5;
    localparam int RESET_CYCLES    = 11;
    localparam int CYCLE_LIMIT     = 400000;
    localparam int HOLD_OFF_CYCLES = 80;
    localparam int QUIET_CYCLES    = 8;
    localparam int TAIL_CYCLES     = 20;
    localparam int REPAIR_CAP      = (FRAME_MAX_DEFAULT < REPAIR_CAP_LIMIT)
                                     ? FRAME_MAX_DEFAULT : REPAIR_CAP_LIMIT;
    localparam int LONG_FRAME_LEN  = 40;

    logic clk;
    logic rst_n;

    adcir_stream_if #(.payload_t(sample_beat_t)) sample_if ();
    adcir_stream_if #(.payload_t(result_beat_t)) result_if ();
    adcir_stream_if #(.payload_t(cfg_beat_t))    cfg_if ();

    adc_impulse_repair_filter dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .sample_in  (sample_if.sink),
        .result_out (result_if.source),
        .cfg        (cfg_if.sink)
    );

    // Sample beats waiting to be offered, and result beats still owed by the filter.
    sample_beat_t codes_to_send[$];
    result_beat_t repaired_due[$];

    // The bench's copy of the filter state. The left neighbor is the previous
    // output code, which is already repaired.
    int spike_thr    = THRESHOLD_RESET;
    int pair_limit   = LIMIT_RESET;
    int left_out     = 0;
    int held_sample  = 0;
    bit held_present = 1'b0;
    bit held_leads   = 1'b0;
    int frame_lo     = CODE_MAX;
    int frame_hi     = 0;
    int fixes_made   = 0;

    // Run bookkeeping.
    int mismatches      = 0;
    int results_checked = 0;
    int frames_closed   = 0;
    int repairs_seen    = 0;
    int settings_used   = 0;
    int cycle_count     = 0;

    // Traffic shaping. The stimulus process owns idle_on and hold_requests;
    // the driver and the ready process own their own countdowns.
    bit idle_on       = 1'b1;
    int hold_requests = 0;
    int hold_served   = 0;
    int hold_left     = 0;
    int stall_left    = 0;
    int send_gap      = 0;
    bit sample_taken  = 1'b0;
    int walk_code     = 2048;

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // Every input of the filter is known from time zero on.
    initial
    begin
        rst_n             = 1'b0;
        sample_if.valid   = 1'b0;
        sample_if.data    = '0;
        result_if.ready   = 1'b0;
        cfg_if.valid      = 1'b0;
        cfg_if.data       = '0;
    end

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        mismatches++;
    endtask

    function automatic void note_output(input int code);
        if (code < frame_lo)
            frame_lo = code;
        if (code > frame_hi)
            frame_hi = code;
    endfunction

    // Works out the result beats that one accepted sample beat causes. The held
    // sample is decided now that its right neighbor is known, using the
    // register values in force at this moment.
    task automatic filter_sample(input sample_beat_t beat);
        result_beat_t r;
        int code;
        int out_code;
        int mid;
        int dev;
        int gap;
        bit fixed;
        code = beat.sample_code;
        if (held_present)
        begin
            out_code = held_sample;
            fixed    = 1'b0;
            if (!held_leads)
            begin
                mid = (left_out + code + 1) / 2;
                dev = (held_sample > mid) ? held_sample - mid : mid - held_sample;
                gap = (left_out > code) ? left_out - code : code - left_out;
                if (dev >= spike_thr && gap <= pair_limit)
                begin
                    out_code = mid;
                    fixed    = 1'b1;
                    if (fixes_made < REPAIR_CAP)
                        fixes_made++;
                    repairs_seen++;
                end
            end
            note_output(out_code);
            left_out       = out_code;
            r              = '0;
            r.repaired_code = out_code[CODE_W-1:0];
            r.was_repaired  = fixed;
            repaired_due.push_back(r);
            held_sample = code;
            held_leads  = 1'b0;
        end
        else
        begin
            held_sample  = code;
            held_present = 1'b1;
            held_leads   = 1'b1;
        end
        // The frame's last sample always goes out unrepaired with the frame
        // statistics, and the frame state starts over.
        if (beat.frame_end)
        begin
            note_output(code);
            r               = '0;
            r.repaired_code = code[CODE_W-1:0];
            r.frame_done    = 1'b1;
            r.frame_minimum = frame_lo[CODE_W-1:0];
            r.frame_maximum = frame_hi[CODE_W-1:0];
            r.repair_total  = fixes_made[COUNT_W-1:0];
            repaired_due.push_back(r);
            frames_closed++;
            frame_lo     = CODE_MAX;
            frame_hi     = 0;
            fixes_made   = 0;
            held_present = 1'b0;
            held_leads   = 1'b0;
            held_sample  = 0;
            left_out     = 0;
        end
    endtask

    // Sample driver. A beat that is on offer stays unchanged until it is taken.
    // New beats and idle bursts are only chosen after a handshake or an idle cycle.
    always @(negedge clk)
    begin
        if (!rst_n)
            sample_if.valid <= 1'b0;
        else if (sample_if.valid && !sample_taken)
            sample_if.valid <= 1'b1;
        else if (send_gap > 0)
        begin
            send_gap--;
            sample_if.valid <= 1'b0;
        end
        else if (codes_to_send.size() != 0)
        begin
            if (idle_on && $urandom_range(0, 9) == 0)
            begin
                send_gap = $urandom_range(0, 5);
                sample_if.valid <= 1'b0;
            end
            else
            begin
                sample_if.valid <= 1'b1;
                sample_if.data  <= codes_to_send[0];
            end
        end
        else
            sample_if.valid <= 1'b0;
    end

    // Result ready. A requested hold-off keeps ready low for a long stretch so
    // that the filter's queue fills up and it stops taking samples.
    always @(negedge clk)
    begin
        if (!rst_n)
            result_if.ready <= 1'b0;
        else if (hold_served != hold_requests)
        begin
            hold_served++;
            hold_left = HOLD_OFF_CYCLES - 1;
            result_if.ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left--;
            result_if.ready <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            result_if.ready <= 1'b0;
        end
        else if (idle_on && $urandom_range(0, 7) == 0)
        begin
            stall_left = $urandom_range(0, 5);
            result_if.ready <= 1'b0;
        end
        else
            result_if.ready <= 1'b1;
    end

    // Sample side of the monitor: an accepted beat leaves the send queue and
    // goes through the prediction.
    always @(posedge clk)
    begin
        sample_taken = rst_n && sample_if.valid && sample_if.ready;
        if (sample_taken)
        begin
            void'(codes_to_send.pop_front());
            filter_sample(sample_if.data);
        end
    end

    // Result side of the monitor: every accepted result beat is compared
    // field by field with the oldest awaited one.
    always @(posedge clk)
    begin
        result_beat_t got;
        result_beat_t want;
        if (rst_n && result_if.valid && result_if.ready)
        begin
            got = result_if.data;
            results_checked++;
            if (repaired_due.size() == 0)
                report_mismatch($sformatf("unexpected result beat, code %0d done %0b",
                                          got.repaired_code, got.frame_done));
            else
            begin
                want = repaired_due.pop_front();
                if (got.repaired_code !== want.repaired_code)
                    report_mismatch($sformatf("repaired_code %0d, expected %0d",
                                              got.repaired_code, want.repaired_code));
                if (got.was_repaired !== want.was_repaired)
                    report_mismatch($sformatf("was_repaired %0b, expected %0b (code %0d)",
                                              got.was_repaired, want.was_repaired,
                                              want.repaired_code));
                if (got.frame_done !== want.frame_done)
                    report_mismatch($sformatf("frame_done %0b, expected %0b (code %0d)",
                                              got.frame_done, want.frame_done,
                                              want.repaired_code));
                if (got.frame_minimum !== want.frame_minimum)
                    report_mismatch($sformatf("frame_minimum %0d, expected %0d",
                                              got.frame_minimum, want.frame_minimum));
                if (got.frame_maximum !== want.frame_maximum)
                    report_mismatch($sformatf("frame_maximum %0d, expected %0d",
                                              got.frame_maximum, want.frame_maximum));
                if (got.repair_total !== want.repair_total)
                    report_mismatch($sformatf("repair_total %0d, expected %0d",
                                              got.repair_total, want.repair_total));
            end
        end
    end

    // Watchdog: a run that hangs ends here.
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("adc_impulse_repair_filter_tb failed");
        $finish;
    end

    task automatic queue_beat(input int code, input bit last);
        sample_beat_t b;
        b.sample_code = code[CODE_W-1:0];
        b.frame_end   = last;
        codes_to_send.push_back(b);
    endtask

    task automatic wait_results_drained();
        while (codes_to_send.size() != 0 || repaired_due.size() != 0)
            @(posedge clk);
    endtask

    // A held first sample causes no result, so the filter may still be busy
    // with it when the last awaited beat has arrived. The quiet stretch passes
    // before a register is touched.
    task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
                                  input logic [CODE_W-1:0] value);
        wait_results_drained();
        repeat (QUIET_CYCLES) @(posedge clk);
        @(negedge clk);
        cfg_if.valid <= 1'b1;
        cfg_if.data  <= '{index: idx, value: value};
        do
            @(posedge clk);
        while (!cfg_if.ready);
        if (idx == REG_SPIKE_THRESHOLD)
            spike_thr = value;
        else if (idx == REG_NEIGHBOR_LIMIT)
            pair_limit = value;
        @(negedge clk);
        cfg_if.valid <= 1'b0;
    endtask

    task automatic set_thresholds(input int thr, input int lim);
        write_register(REG_SPIKE_THRESHOLD, thr[CODE_W-1:0]);
        write_register(REG_NEIGHBOR_LIMIT, lim[CODE_W-1:0]);
        settings_used++;
    endtask

    // Picks a register value, leaning toward the ends of the range and toward
    // small values that make repairs a matter of degree.
    function automatic int pick_setting();
        case ($urandom_range(0, 4))
            0:       return 0;
            1:       return CODE_MAX;
            2:       return $urandom_range(0, 64);
            3:       return $urandom_range(64, 900);
            default: return $urandom_range(0, CODE_MAX);
        endcase
    endfunction

    // A smooth signal that wanders with small noise, broken by spikes of any
    // height, jumps to random codes and hits on the rails. Frame ends come at
    // random, so some frames hold a single sample and the stream may stop in
    // the middle of a frame.
    task automatic queue_stream(input int count);
        int code;
        for (int n = 0; n < count; n++)
        begin
            case ($urandom_range(0, 9)) inside
                [0:5]:
                begin
                    code = walk_code + $urandom_range(0, 80) - 40;
                    code = (code < 0) ? 0 : (code > CODE_MAX) ? CODE_MAX : code;
                    walk_code = code;
                end
                [6:7]:
                begin
                    code = ($urandom_range(0, 1) != 0)
                           ? walk_code + $urandom_range(0, CODE_MAX)
                           : walk_code - $urandom_range(0, CODE_MAX);
                    code = (code < 0) ? 0 : (code > CODE_MAX) ? CODE_MAX : code;
                end
                8:
                begin
                    code = $urandom_range(0, CODE_MAX);
                    walk_code = code;
                end
                default:
                    code = ($urandom_range(0, 1) != 0) ? CODE_MAX : 0;
            endcase
            queue_beat(code, $urandom_range(0, 7) == 0);
        end
    endtask

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed frames under the reset thresholds of 512.
        queue_beat(CODE_MAX, 1'b1);          // single-sample frame at the top rail
        queue_beat(0, 1'b1);                 // single-sample frame at the bottom rail
        queue_beat(100, 1'b0);               // clear spike between close neighbors
        queue_beat(2000, 1'b0);
        queue_beat(110, 1'b0);
        queue_beat(120, 1'b1);
        queue_beat(0, 1'b0);                 // spike kept: neighbors too far apart
        queue_beat(CODE_MAX, 1'b0);
        queue_beat(1000, 1'b1);
        queue_beat(1000, 1'b0);              // deviation exactly at the threshold
        queue_beat(1512, 1'b0);
        queue_beat(1000, 1'b0);
        queue_beat(CODE_MAX, 1'b0);          // neighbor gap exactly at the limit
        queue_beat(1512, 1'b0);
        queue_beat(1511, 1'b1);              // deviation of 128, below the threshold
        queue_beat(5, 1'b0);                 // two-sample frame: nothing is repaired
        queue_beat(4000, 1'b1);
        wait_results_drained();

        // Strictest setting: only a full-scale spike between equal rails qualifies.
        set_thresholds(CODE_MAX, 0);
        queue_beat(0, 1'b0);
        queue_beat(CODE_MAX, 1'b0);
        queue_beat(0, 1'b1);
        queue_beat(CODE_MAX, 1'b0);
        queue_beat(0, 1'b0);
        queue_beat(CODE_MAX, 1'b1);
        queue_beat(10, 1'b0);
        queue_beat(CODE_MAX, 1'b0);
        queue_beat(11, 1'b1);

        // Loosest setting: every inner sample is repaired, even on a flat line.
        // The long frame keeps the repair count climbing sample after sample.
        set_thresholds(0, CODE_MAX);
        queue_beat(7, 1'b0);
        queue_beat(7, 1'b0);
        queue_beat(7, 1'b1);
        for (int n = 0; n < LONG_FRAME_LEN; n++)
            queue_beat($urandom_range(0, CODE_MAX), n == LONG_FRAME_LEN - 1);

        // Random phases. The stream may stop mid-frame, so the next register
        // write lands while a sample is held.
        set_thresholds(pick_setting(), pick_setting());
        queue_stream(80);

        // The sink holds off for a long stretch while samples keep coming.
        set_thresholds($urandom_range(0, 600), $urandom_range(200, CODE_MAX));
        hold_requests++;
        queue_stream(80);

        // The source pauses halfway until every awaited beat has come back.
        set_thresholds(pick_setting(), pick_setting());
        queue_stream(40);
        wait_results_drained();
        queue_stream(40);

        // Last part at full rate on both sides, then close the open frame.
        set_thresholds($urandom_range(0, 300), $urandom_range(300, CODE_MAX));
        idle_on = 1'b0;
        queue_stream(80);
        queue_beat($urandom_range(0, CODE_MAX), 1'b1);

        wait_results_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (repaired_due.size() != 0)
            report_mismatch($sformatf("%0d result beats never arrived", repaired_due.size()));

        $display("Run covered %0d result beats in %0d frames, %0d of them repaired spikes,",
                 results_checked, frames_closed, repairs_seen);
        $display("under %0d threshold settings besides the reset one; %0d mismatches.",
                 settings_used, mismatches);
        if (mismatches == 0)
            $display("adc_impulse_repair_filter_tb passed");
        else
            $display("adc_impulse_repair_filter_tb failed");
        $finish;
    end

endmodule
